// ===== sv/hti_pkg.sv =====
`timescale 1ns / 1ps
package hti_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int FRACTION_BITS = 16;
    localparam int COEF_BITS     = 14;
    localparam int CFG_BITS      = 16;
    localparam int CFG_IDX_W     = 1;

    // length of the valid shift register beside the data path
    localparam int PIPE_DEPTH = 9;

    localparam int DIFF_W  = SAMPLE_BITS + 1;
    localparam int WFAC_W  = CFG_BITS + 1;
    localparam int WPROD_W = 2 * WFAC_W;
    localparam int W_W     = WPROD_W - COEF_BITS;
    localparam int TPROD_W = DIFF_W + W_W;
    localparam int TSUM_W  = TPROD_W + 1;
    localparam int M_W     = TSUM_W - COEF_BITS - 1;
    localparam int H_W     = FRACTION_BITS + 3;
    localparam int HP_W    = H_W + M_W;
    localparam int ACC_W   = HP_W + 2;

    localparam logic [CFG_IDX_W-1:0] REG_TENSION = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BIAS    = CFG_IDX_W'(1);

    localparam logic signed [WFAC_W-1:0]  COEF_ONE   = WFAC_W'(1) << COEF_BITS;
    localparam logic signed [WPROD_W-1:0] WPROD_ONE  = WPROD_W'(1) << (2 * COEF_BITS);
    localparam logic signed [WPROD_W-1:0] WPROD_HALF = WPROD_W'(1) << (COEF_BITS - 1);
    localparam logic signed [W_W-1:0]     W_ONE      = W_W'(1) << COEF_BITS;
    localparam logic signed [TSUM_W-1:0]  TSUM_HALF  = TSUM_W'(1) << COEF_BITS;
    localparam logic [2*FRACTION_BITS:0]  U_HALF     =
        (2 * FRACTION_BITS + 1)'(1) << (FRACTION_BITS - 1);
    localparam logic signed [H_W-1:0]     H_ONE      = H_W'(1) << FRACTION_BITS;
    localparam logic signed [ACC_W-1:0]   ACC_HALF   = ACC_W'(1) << (FRACTION_BITS - 1);
    localparam logic signed [ACC_W-1:0]   ACC_SMAX   =
        {{(ACC_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0]   ACC_SMIN   = ~ACC_SMAX;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX =
        {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN =
        {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_before;
        logic signed [SAMPLE_BITS-1:0] sample_start;
        logic signed [SAMPLE_BITS-1:0] sample_end;
        logic signed [SAMPLE_BITS-1:0] sample_after;
        logic [FRACTION_BITS-1:0]      position;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] interpolated;
        logic                          saturated;
    } t_out_item;

    typedef struct packed {
        logic signed [W_W-1:0] wa;
        logic signed [W_W-1:0] wb;
    } t_tan_coef;

    typedef struct packed {
        logic signed [H_W-1:0] h00;
        logic signed [H_W-1:0] h10;
        logic signed [H_W-1:0] h01;
        logic signed [H_W-1:0] h11;
    } t_basis;

    typedef struct packed {
        logic signed [M_W-1:0]         m0;
        logic signed [M_W-1:0]         m1;
        logic signed [SAMPLE_BITS-1:0] sample_start;
        logic signed [SAMPLE_BITS-1:0] sample_end;
    } t_tan;

endpackage

// ===== sv/hti_cfg.sv =====
`timescale 1ns / 1ps
module hti_cfg
    import hti_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_BITS-1:0]  i_cfg_wdata,
    output t_tan_coef            o_coef
);

    logic signed [CFG_BITS-1:0] r_tension;
    logic signed [CFG_BITS-1:0] r_bias;
    logic signed [WPROD_W-1:0]  r_prod_a;
    logic signed [WPROD_W-1:0]  r_prod_b;
    t_tan_coef                  r_coef;

    logic signed [WFAC_W-1:0]  w_fa;
    logic signed [WFAC_W-1:0]  w_fb;
    logic signed [WFAC_W-1:0]  w_ft;
    logic signed [WPROD_W-1:0] n_prod_a;
    logic signed [WPROD_W-1:0] n_prod_b;
    logic signed [WPROD_W-1:0] w_rnd_a;
    logic signed [WPROD_W-1:0] w_rnd_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tension <= '0;
            r_bias    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TENSION: r_tension <= signed'(i_cfg_wdata);
                REG_BIAS:    r_bias    <= signed'(i_cfg_wdata);
                default:     ;
            endcase
        end
    end

    // (1 +- b) and (1 - t) in Q14
    assign w_fa = COEF_ONE + WFAC_W'(r_bias);
    assign w_fb = COEF_ONE - WFAC_W'(r_bias);
    assign w_ft = COEF_ONE - WFAC_W'(r_tension);

    assign n_prod_a = WPROD_W'(w_fa) * WPROD_W'(w_ft);
    assign n_prod_b = WPROD_W'(w_fb) * WPROD_W'(w_ft);

    assign w_rnd_a = (r_prod_a + WPROD_HALF) >>> COEF_BITS;
    assign w_rnd_b = (r_prod_b + WPROD_HALF) >>> COEF_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_a  <= WPROD_ONE;
            r_prod_b  <= WPROD_ONE;
            r_coef.wa <= W_ONE;
            r_coef.wb <= W_ONE;
        end else begin
            r_prod_a  <= n_prod_a;
            r_prod_b  <= n_prod_b;
            r_coef.wa <= W_W'(w_rnd_a);
            r_coef.wb <= W_W'(w_rnd_b);
        end
    end

    assign o_coef = r_coef;

endmodule

// ===== sv/hti_basis.sv =====
`timescale 1ns / 1ps
module hti_basis
    import hti_pkg::*;
(
    input  logic                     i_clk,
    input  logic [FRACTION_BITS-1:0] i_pos,
    output t_basis                   o_basis
);

    logic [2*FRACTION_BITS-1:0] r_uu;
    logic [FRACTION_BITS-1:0]   r_u_2;
    logic [FRACTION_BITS-1:0]   r_u2;
    logic [FRACTION_BITS-1:0]   r_u_3;
    logic [2*FRACTION_BITS-1:0] r_u3p;
    logic [FRACTION_BITS-1:0]   r_u2_4;
    logic [FRACTION_BITS-1:0]   r_u_4;
    logic [FRACTION_BITS-1:0]   r_u3;
    logic [FRACTION_BITS-1:0]   r_u2_5;
    logic [FRACTION_BITS-1:0]   r_u_5;
    t_basis                     r_basis;

    logic [2*FRACTION_BITS:0] w_uu_rnd;
    logic [2*FRACTION_BITS:0] w_u3_rnd;
    logic signed [H_W-1:0]    w_u;
    logic signed [H_W-1:0]    w_u2;
    logic signed [H_W-1:0]    w_u3;

    assign w_uu_rnd = {1'b0, r_uu} + U_HALF;
    assign w_u3_rnd = {1'b0, r_u3p} + U_HALF;

    assign w_u  = signed'(H_W'(r_u_5));
    assign w_u2 = signed'(H_W'(r_u2_5));
    assign w_u3 = signed'(H_W'(r_u3));

    always_ff @(posedge i_clk) begin
        r_uu        <= (2 * FRACTION_BITS)'(i_pos) * (2 * FRACTION_BITS)'(i_pos);
        r_u_2       <= i_pos;
        r_u2        <= w_uu_rnd[FRACTION_BITS +: FRACTION_BITS];
        r_u_3       <= r_u_2;
        r_u3p       <= (2 * FRACTION_BITS)'(r_u2) * (2 * FRACTION_BITS)'(r_u_3);
        r_u2_4      <= r_u2;
        r_u_4       <= r_u_3;
        r_u3        <= w_u3_rnd[FRACTION_BITS +: FRACTION_BITS];
        r_u2_5      <= r_u2_4;
        r_u_5       <= r_u_4;
        r_basis.h00 <= (w_u3 <<< 1) - (w_u2 + (w_u2 <<< 1)) + H_ONE;
        r_basis.h10 <= w_u3 - (w_u2 <<< 1) + w_u;
        r_basis.h01 <= w_u3 - w_u2;
        r_basis.h11 <= (w_u2 + (w_u2 <<< 1)) - (w_u3 <<< 1);
    end

    assign o_basis = r_basis;

endmodule

// ===== sv/hti_tangent.sv =====
`timescale 1ns / 1ps
module hti_tangent
    import hti_pkg::*;
(
    input  logic      i_clk,
    input  t_in_item  i_item,
    input  t_tan_coef i_coef,
    output t_tan      o_tan
);

    logic signed [DIFF_W-1:0]      r_d0;
    logic signed [DIFF_W-1:0]      r_d1;
    logic signed [DIFF_W-1:0]      r_d2;
    logic signed [SAMPLE_BITS-1:0] r_v1_2;
    logic signed [SAMPLE_BITS-1:0] r_v2_2;
    logic signed [TPROD_W-1:0]     r_pa0;
    logic signed [TPROD_W-1:0]     r_pb0;
    logic signed [TPROD_W-1:0]     r_pa1;
    logic signed [TPROD_W-1:0]     r_pb1;
    logic signed [SAMPLE_BITS-1:0] r_v1_3;
    logic signed [SAMPLE_BITS-1:0] r_v2_3;
    t_tan                          r_tan_4;
    t_tan                          r_tan_5;
    t_tan                          r_tan_6;

    logic signed [TSUM_W-1:0] w_sum0;
    logic signed [TSUM_W-1:0] w_sum1;

    // shift by COEF_BITS + 1 folds the halving into the Q14 scale
    assign w_sum0 = (TSUM_W'(r_pa0) + TSUM_W'(r_pb0) + TSUM_HALF) >>> (COEF_BITS + 1);
    assign w_sum1 = (TSUM_W'(r_pa1) + TSUM_W'(r_pb1) + TSUM_HALF) >>> (COEF_BITS + 1);

    always_ff @(posedge i_clk) begin
        r_d0   <= DIFF_W'(i_item.sample_start) - DIFF_W'(i_item.sample_before);
        r_d1   <= DIFF_W'(i_item.sample_end) - DIFF_W'(i_item.sample_start);
        r_d2   <= DIFF_W'(i_item.sample_after) - DIFF_W'(i_item.sample_end);
        r_v1_2 <= i_item.sample_start;
        r_v2_2 <= i_item.sample_end;

        r_pa0  <= TPROD_W'(r_d0) * TPROD_W'(i_coef.wa);
        r_pb0  <= TPROD_W'(r_d1) * TPROD_W'(i_coef.wb);
        r_pa1  <= TPROD_W'(r_d1) * TPROD_W'(i_coef.wa);
        r_pb1  <= TPROD_W'(r_d2) * TPROD_W'(i_coef.wb);
        r_v1_3 <= r_v1_2;
        r_v2_3 <= r_v2_2;

        r_tan_4.m0           <= M_W'(w_sum0);
        r_tan_4.m1           <= M_W'(w_sum1);
        r_tan_4.sample_start <= r_v1_3;
        r_tan_4.sample_end   <= r_v2_3;

        // lines up with the basis weights
        r_tan_5 <= r_tan_4;
        r_tan_6 <= r_tan_5;
    end

    assign o_tan = r_tan_6;

endmodule

// ===== sv/hti_blend.sv =====
`timescale 1ns / 1ps
module hti_blend
    import hti_pkg::*;
(
    input  logic      i_clk,
    input  t_basis    i_basis,
    input  t_tan      i_tan,
    output t_out_item o_result
);

    logic signed [HP_W-1:0]  r_p0;
    logic signed [HP_W-1:0]  r_p1;
    logic signed [HP_W-1:0]  r_p2;
    logic signed [HP_W-1:0]  r_p3;
    logic signed [ACC_W-1:0] r_acc;
    t_out_item               r_out;

    logic signed [ACC_W-1:0] w_res;
    t_out_item               n_out;

    assign w_res = r_acc >>> FRACTION_BITS;

    always_comb begin
        if (w_res > ACC_SMAX) begin
            n_out.interpolated = SAMPLE_MAX;
            n_out.saturated    = 1'b1;
        end else if (w_res < ACC_SMIN) begin
            n_out.interpolated = SAMPLE_MIN;
            n_out.saturated    = 1'b1;
        end else begin
            n_out.interpolated = w_res[SAMPLE_BITS-1:0];
            n_out.saturated    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p0  <= HP_W'(i_basis.h00) * HP_W'(i_tan.sample_start);
        r_p1  <= HP_W'(i_basis.h10) * HP_W'(i_tan.m0);
        r_p2  <= HP_W'(i_basis.h01) * HP_W'(i_tan.m1);
        r_p3  <= HP_W'(i_basis.h11) * HP_W'(i_tan.sample_end);
        r_acc <= ACC_W'(r_p0) + ACC_W'(r_p1) + ACC_W'(r_p2) + ACC_W'(r_p3) + ACC_HALF;
        r_out <= n_out;
    end

    assign o_result = r_out;

endmodule

// ===== sv/hermite_tension_bias_interpolator.sv =====
`timescale 1ns / 1ps
// channel   direction  handshake                   payload
// input     in         start high, busy low        i_data (t_in_item)
// result    out        o_done, one cycle, no stall o_result (t_out_item)
// config    in         i_cfg_we                    i_cfg_idx, i_cfg_wdata
//
// one transaction per clock while busy is low; the result passes through
// the nine register stages of the multiply path, from r_in to the output
// synchronous reset clears the config registers and the valid pipe; busy
// is high while reset is held and drops at the first edge after its release
// the tangent weights pass through the product and coefficient registers after a
// config write, in time for a transaction accepted on the following edge
module hermite_tension_bias_interpolator
    import hti_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_in_item             i_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_BITS-1:0]  i_cfg_wdata,
    output logic                 o_done,
    output t_out_item            o_result
);

    logic                  r_busy;
    logic [PIPE_DEPTH-1:0] r_vld;
    t_in_item              r_in;

    logic      w_accept;
    t_tan_coef w_coef;
    t_basis    w_basis;
    t_tan      w_tan;

    assign w_accept = start && !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_vld  <= '0;
        end else begin
            r_busy <= 1'b0;
            r_vld  <= {r_vld[PIPE_DEPTH-2:0], w_accept};
        end
    end

    always_ff @(posedge i_clk) begin
        r_in <= i_data;
    end

    hti_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_coef      (w_coef)
    );

    hti_basis u_basis (
        .i_clk   (i_clk),
        .i_pos   (r_in.position),
        .o_basis (w_basis)
    );

    hti_tangent u_tangent (
        .i_clk  (i_clk),
        .i_item (r_in),
        .i_coef (w_coef),
        .o_tan  (w_tan)
    );

    hti_blend u_blend (
        .i_clk    (i_clk),
        .i_basis  (w_basis),
        .i_tan    (w_tan),
        .o_result (o_result)
    );

    assign busy   = r_busy;
    assign o_done = r_vld[PIPE_DEPTH-1];

endmodule

// ===== sv/hti_checker.sv =====
`timescale 1ns / 1ps
module hti_checker
    import hti_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input logic      busy,
    input t_in_item  i_data,
    input logic      o_done,
    input t_out_item o_result
);

    // every accepted transaction comes back with o_done
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##PIPE_DEPTH o_done)
        else $error("result missing after accepted transaction");

    // no result without a transaction behind it
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, PIPE_DEPTH))
        else $error("result without accepted transaction");

    // position zero gives back the start sample unchanged
    a_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_data.position == '0)) |-> ##PIPE_DEPTH
        ((o_result.interpolated == $past(i_data.sample_start, PIPE_DEPTH)) &&
         !o_result.saturated))
        else $error("position zero did not return start sample");

    // clamped results sit on a range limit
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.saturated) |->
        ((o_result.interpolated == SAMPLE_MAX) || (o_result.interpolated == SAMPLE_MIN)))
        else $error("saturated result not at a range limit");

endmodule

bind hermite_tension_bias_interpolator hti_checker u_hti_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_data   (i_data),
    .o_done   (o_done),
    .o_result (o_result)
);

// ===== tb/tb_hermite_tension_bias_interpolator.sv =====
`timescale 1ns / 1ps
module tb_hermite_tension_bias_interpolator;
    import hti_pkg::*;

    localparam int GAP_MAX     = 6;
    localparam int PHASE_ITEMS = 100;
    localparam int N_PHASES    = 10;
    localparam int N_SET       = 8;
    localparam int N_DIRECTED  = 12;

    typedef struct packed {
        t_in_item  item;
        logic      typed;
        t_out_item want;
    } t_stim_row;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 start       = 1'b0;
    logic                 busy;
    t_in_item             i_data      = '0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx   = REG_TENSION;
    logic [CFG_BITS-1:0]  i_cfg_wdata = '0;
    logic                 o_done;
    t_out_item            o_result;

    logic signed [CFG_BITS-1:0] tension_q = '0;
    logic signed [CFG_BITS-1:0] bias_q    = '0;
    t_out_item                  pending_results[$];
    int                         error_count = 0;
    int                         idle_max    = GAP_MAX;

    // typed rows: position zero gives sample_start, big swings clip to the rails, a flat rail holds
    t_stim_row directed_rows [N_DIRECTED] = '{
        '{'{-100, 200, 300, 400, 0}, 1'b1, '{200, 1'b0}},
        '{'{-32768, 32767, -32768, 32767, 0}, 1'b1, '{32767, 1'b0}},
        '{'{32767, -32768, 32767, -32768, 0}, 1'b1, '{-32768, 1'b0}},
        '{'{0, 0, 0, 0, 0}, 1'b1, '{0, 1'b0}},
        '{'{-32768, 32767, 32767, -32768, 32768}, 1'b1, '{32767, 1'b1}},
        '{'{32767, -32768, -32768, 32767, 32768}, 1'b1, '{-32768, 1'b1}},
        '{'{32767, 32767, 32767, 32767, 40000}, 1'b1, '{32767, 1'b0}},
        '{'{-32768, 32767, -32768, 32767, 65535}, 1'b0, '{0, 1'b0}},
        '{'{32767, -32768, 32767, -32768, 1}, 1'b0, '{0, 1'b0}},
        '{'{-1, 0, -1, 0, 65535}, 1'b0, '{0, 1'b0}},
        '{'{1000, -2000, 3000, -4000, 21845}, 1'b0, '{0, 1'b0}},
        '{'{-32768, -32768, 32767, 32767, 49152}, 1'b0, '{0, 1'b0}}
    };

    logic signed [CFG_BITS-1:0] phase_tension [N_SET] =
        '{16384, -16384, 0, 0, 16384, -16384, -32768, 32767};
    logic signed [CFG_BITS-1:0] phase_bias [N_SET] =
        '{0, 0, 16384, -16384, 16384, -16384, 32767, -32768};

    hermite_tension_bias_interpolator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_data      (i_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_done      (o_done),
        .o_result    (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // add half an lsb, then floor
    function automatic longint round_shift(input longint x, input int s);
        return (x + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic t_out_item hermite_value(input t_in_item it,
                                                input logic signed [CFG_BITS-1:0] tn,
                                                input logic signed [CFG_BITS-1:0] bs);
        longint    p0, p1, p2, p3, u, u2, u3;
        longint    h00, h10, h01, h11, wa, wb, m0, m1, acc, r;
        longint    unit_w;
        t_out_item res;
        p0     = longint'($signed(it.sample_before));
        p1     = longint'($signed(it.sample_start));
        p2     = longint'($signed(it.sample_end));
        p3     = longint'($signed(it.sample_after));
        u      = longint'(it.position);
        unit_w = longint'(1) <<< COEF_BITS;
        u2  = round_shift(u * u, FRACTION_BITS);
        u3  = round_shift(u2 * u, FRACTION_BITS);
        h00 = 2 * u3 - 3 * u2 + (longint'(1) <<< FRACTION_BITS);
        h10 = u3 - 2 * u2 + u;
        h01 = u3 - u2;
        h11 = -2 * u3 + 3 * u2;
        wa  = round_shift((unit_w + longint'(bs)) * (unit_w - longint'(tn)), COEF_BITS);
        wb  = round_shift((unit_w - longint'(bs)) * (unit_w - longint'(tn)), COEF_BITS);
        m0  = round_shift((p1 - p0) * wa + (p2 - p1) * wb, COEF_BITS + 1);
        m1  = round_shift((p2 - p1) * wa + (p3 - p2) * wb, COEF_BITS + 1);
        acc = h00 * p1 + h10 * m0 + h01 * m1 + h11 * p2;
        r   = round_shift(acc, FRACTION_BITS);
        res.saturated = 1'b0;
        if (r > longint'(SAMPLE_MAX)) begin
            r = longint'(SAMPLE_MAX);
            res.saturated = 1'b1;
        end else if (r < longint'(SAMPLE_MIN)) begin
            r = longint'(SAMPLE_MIN);
            res.saturated = 1'b1;
        end
        res.interpolated = r[SAMPLE_BITS-1:0];
        return res;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] edge_sample();
        case ($urandom_range(0, 3))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return '0;
            default: return '1;
        endcase
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(input int mode,
                                                                  input int base);
        if (mode < 5)
            return SAMPLE_BITS'(base + int'($urandom_range(0, 8000)) - 4000);
        if (mode < 8 || $urandom_range(0, 1) == 0)
            return SAMPLE_BITS'($urandom);
        return edge_sample();
    endfunction

    // smooth curves in half the modes, else full-range noise and rail values
    function automatic t_in_item random_item();
        t_in_item it;
        int       mode;
        int       base;
        mode = $urandom_range(0, 9);
        base = int'($urandom_range(0, 40000)) - 20000;
        it.sample_before = pick_sample(mode, base);
        it.sample_start  = pick_sample(mode, base);
        it.sample_end    = pick_sample(mode, base);
        it.sample_after  = pick_sample(mode, base);
        case ($urandom_range(0, 15))
            0: it.position = '0;
            1: it.position = '1;
            2: it.position = FRACTION_BITS'(1);
            default: it.position = FRACTION_BITS'($urandom);
        endcase
        return it;
    endfunction

    task automatic send_item(input t_in_item item, input logic typed, input t_out_item want);
        int gap;
        gap = $urandom_range(0, idle_max);
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start  <= 1'b1;
        i_data <= item;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_results.push_back(typed ? want : hermite_value(item, tension_q, bias_q));
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_coefs(input logic signed [CFG_BITS-1:0] tn,
                               input logic signed [CFG_BITS-1:0] bs);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= REG_TENSION;
        i_cfg_wdata <= tn;
        @(posedge i_clk);
        tension_q = tn;
        @(negedge i_clk);
        i_cfg_idx   <= REG_BIAS;
        i_cfg_wdata <= bs;
        @(posedge i_clk);
        bias_q = bs;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_done === 1'b1) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected transaction: expected none, actual %0d/%0b",
                         $time, $signed(o_result.interpolated), o_result.saturated);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_result.interpolated !== want.interpolated) begin
                    $display("%0t: interpolated mismatch: expected %0d, actual %0d",
                             $time, $signed(want.interpolated),
                             $signed(o_result.interpolated));
                    error_count++;
                end
                if (o_result.saturated !== want.saturated) begin
                    $display("%0t: saturated mismatch: expected %0b, actual %0b",
                             $time, want.saturated, o_result.saturated);
                    error_count++;
                end
            end
        end
    end

    initial begin
        logic signed [CFG_BITS-1:0] tn;
        logic signed [CFG_BITS-1:0] bs;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain_results();
            if (ph < N_SET) begin
                tn = phase_tension[ph];
                bs = phase_bias[ph];
            end else begin
                tn = CFG_BITS'(int'($urandom_range(0, 32768)) - 16384);
                bs = CFG_BITS'(int'($urandom_range(0, 32768)) - 16384);
            end
            write_coefs(tn, bs);
            // some phases run back to back with no gaps
            idle_max = (ph % 3 == 2) ? 0 : GAP_MAX;
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_item(random_item(), 1'b0, '0);
        end

        drain_results();
        repeat (PIPE_DEPTH + 4) @(posedge i_clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
